// ===== src/mvsm_pkg.sv =====
// shared types, constants and helpers for the multi-voice sample mixer
// no dependencies; used by the voice memory and the top level
package mvsm_pkg;

    localparam int VOICES_DEF       = 30;
    localparam int SAMPLE_DEPTH_DEF = 65536;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUEUE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // saturation bounds and results
    localparam logic signed [16:0] SUM_MAX   = 17'sd32767;
    localparam logic signed [16:0] SUM_MIN   = -17'sd32768;
    localparam logic signed [15:0] CLIP_HIGH = 16'sd32766;
    localparam logic signed [15:0] CLIP_LOW  = -16'sd32767;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] length;
        logic [16:0] position;
    } voice_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUEUE,
        ST_TICK,
        ST_DONE
    } mix_state_t;

    function automatic logic signed [15:0] clip_add(input logic signed [15:0] acc,
                                                    input logic signed [15:0] smp);
        logic signed [16:0] sum;
        logic signed [15:0] res;
        sum = 17'(acc) + 17'(smp);
        if (sum > SUM_MAX) begin
            res = CLIP_HIGH;
        end
        else if (sum < SUM_MIN) begin
            res = CLIP_LOW;
        end
        else begin
            res = sum[15:0];
        end
        return res;
    endfunction

endpackage

// ===== src/mvsm_item_if.sv =====
// input channel of the mixer: command item with valid/ready handshake
// no dependencies
interface mvsm_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [16:0]        sample_count;

    modport source (output valid, output cmd, output address, output sample_value,
                    output sample_count, input ready);
    modport sink (input valid, input cmd, input address, input sample_value,
                  input sample_count, output ready);
endinterface

// ===== src/mvsm_result_if.sv =====
// output channel of the mixer: result item with valid/ready handshake
// no dependencies
interface mvsm_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mixed_sample;
    logic               status;
    logic [4:0]         slot;
    logic [4:0]         active_voices;

    modport source (output valid, output mixed_sample, output status, output slot,
                    output active_voices, input ready);
    modport sink (input valid, input mixed_sample, input status, input slot,
                  input active_voices, output ready);
endinterface

// ===== src/multi_voice_sample_mixer_unit.sv =====
// top level of the multi-voice sample mixer: sequencer, busy flags, mix pipeline
// depends on mvsm_pkg, mvsm_item_if, mvsm_result_if, mvsm_sample_mem, mvsm_voice_mem
//
//  channel  | role   | payload                                        | transfer
//  ---------+--------+------------------------------------------------+------------------
//  item     | sink   | cmd, address, sample_value, sample_count       | valid && ready
//  result   | source | mixed_sample, status, slot, active_voices      | valid && ready
//
// per item: load is taken in idle, queue walks the busy flags one slot a cycle for the
// first free slot, tick reads the voice memory one slot per cycle over all slots and the
// shared clip-add unit follows behind it through the voice read, stage 1 and the sample
// read, so the busy state of the last slots sets the drain
// rst_n clears busy flags, voice count and control; no clearing pass, sample memory
// holds garbage until loaded and voice entries are only used while busy
// an item is taken while a previous result still sits in the output register;
// a finished result waits in the done state until the output register frees up
module multi_voice_sample_mixer_unit #(
    parameter int VOICES       = mvsm_pkg::VOICES_DEF,
    parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
    input logic           clk,
    input logic           rst_n,
    mvsm_item_if.sink     item,
    mvsm_result_if.source result
);

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW    = $clog2(VOICES + 1);
    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int SUMW  = 18;

    // sequencer
    mvsm_pkg::mix_state_t state_reg, state_next;

    logic [VW-1:0]      idx_reg;
    logic               walk_done_reg;
    logic               s1_valid_reg;
    logic [VW-1:0]      s1_idx_reg;
    logic               s2_valid_reg;
    logic [VOICES-1:0]  busy_reg;
    logic [CW-1:0]      count_reg;

    // payload registers
    logic signed [15:0] mix_reg;
    logic [15:0]        q_addr_reg;
    logic [16:0]        q_count_reg;
    logic               res_status_reg;
    logic [VW-1:0]      res_slot_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_mixed_reg;
    logic               out_status_reg;
    logic [4:0]         out_slot_reg;
    logic [4:0]         out_active_reg;

    // combinational control
    logic                   item_xfer;
    logic                   idx_last;
    logic                   issue;
    logic                   q_take;
    logic                   play;
    logic                   retire;
    logic [16:0]            pos_inc;
    logic                   done_load;
    logic                   voice_we;
    logic [VW-1:0]          voice_wr_idx;
    mvsm_pkg::voice_entry_t voice_wr_data;
    mvsm_pkg::voice_entry_t voice_rd_data;
    logic                   sample_we;
    logic                   sample_re;
    logic [AW-1:0]          sample_wr_addr;
    logic [AW-1:0]          sample_rd_addr;
    logic signed [15:0]     sample_rd_data;
    logic [SUMW-1:0]        play_sum;
    logic [AW+15:0]         load_addr_ext;
    logic [AW+SUMW-1:0]     play_addr_ext;
    logic [VW+4:0]          slot_ext;
    logic [CW+4:0]          count_ext;

    assign item_xfer  = item.valid && item.ready;
    assign item.ready = (state_reg == mvsm_pkg::ST_IDLE);

    assign idx_last = (idx_reg == VW'(VOICES - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvsm_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    if (item.cmd == mvsm_pkg::CMD_QUEUE)
                    begin
                        state_next = mvsm_pkg::ST_QUEUE;
                    end
                    else if (item.cmd == mvsm_pkg::CMD_TICK)
                    begin
                        state_next = mvsm_pkg::ST_TICK;
                    end
                    else
                    begin
                        state_next = mvsm_pkg::ST_DONE;
                    end
                end
            end
            mvsm_pkg::ST_QUEUE:
            begin
                if (!busy_reg[idx_reg] || idx_last)
                begin
                    state_next = mvsm_pkg::ST_DONE;
                end
            end
            mvsm_pkg::ST_TICK:
            begin
                // walk finished and both pipeline stages drained
                if (walk_done_reg && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = mvsm_pkg::ST_DONE;
                end
            end
            mvsm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = mvsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvsm_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and pipeline stage-1 decode
    always_comb
    begin
        issue     = (state_reg == mvsm_pkg::ST_TICK) && !walk_done_reg;
        q_take    = (state_reg == mvsm_pkg::ST_QUEUE) && !busy_reg[idx_reg];
        done_load = (state_reg == mvsm_pkg::ST_DONE) && (!out_valid_reg || result.ready);

        // stage 1: voice entry read back, decide whether it plays and whether it ends
        play    = (voice_rd_data.position < voice_rd_data.length);
        pos_inc = voice_rd_data.position + 17'd1;
        retire  = !play || (pos_inc >= voice_rd_data.length);

        // new entry on queue, position advance on tick; retired entries are left stale
        voice_we     = q_take || (s1_valid_reg && !retire);
        voice_wr_idx = q_take ? idx_reg : s1_idx_reg;
        if (q_take)
        begin
            voice_wr_data.start    = q_addr_reg;
            voice_wr_data.length   = q_count_reg;
            voice_wr_data.position = 17'd0;
        end
        else
        begin
            voice_wr_data.start    = voice_rd_data.start;
            voice_wr_data.length   = voice_rd_data.length;
            voice_wr_data.position = pos_inc;
        end

        // sample address wraps modulo the memory depth
        play_sum       = {2'b00, voice_rd_data.start} + {1'b0, voice_rd_data.position};
        play_addr_ext  = {{AW{1'b0}}, play_sum};
        sample_rd_addr = play_addr_ext[AW-1:0];
        sample_re      = s1_valid_reg && play;

        load_addr_ext  = {{AW{1'b0}}, item.address};
        sample_wr_addr = load_addr_ext[AW-1:0];
        sample_we      = item_xfer && (item.cmd == mvsm_pkg::CMD_LOAD);

        slot_ext  = {5'b00000, res_slot_reg};
        count_ext = {5'b00000, count_reg};
    end

    mvsm_voice_mem #(
        .VOICES (VOICES),
        .VW     (VW)
    ) u_voice_mem (
        .clk     (clk),
        .wr_en   (voice_we),
        .wr_idx  (voice_wr_idx),
        .wr_data (voice_wr_data),
        .rd_en   (issue),
        .rd_idx  (idx_reg),
        .rd_data (voice_rd_data)
    );

    mvsm_sample_mem #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_sample_mem (
        .clk     (clk),
        .wr_en   (sample_we),
        .wr_addr (sample_wr_addr),
        .wr_data (item.sample_value),
        .rd_en   (sample_re),
        .rd_addr (sample_rd_addr),
        .rd_data (sample_rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvsm_pkg::ST_IDLE;
            idx_reg       <= '0;
            walk_done_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_idx_reg    <= '0;
            s2_valid_reg  <= 1'b0;
            busy_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (item_xfer)
            begin
                idx_reg       <= '0;
                walk_done_reg <= 1'b0;
            end
            else if (state_reg == mvsm_pkg::ST_QUEUE)
            begin
                if (q_take)
                begin
                    busy_reg[idx_reg] <= 1'b1;
                    count_reg         <= count_reg + CW'(1);
                end
                else if (!idx_last)
                begin
                    idx_reg <= idx_reg + VW'(1);
                end
            end
            else if (issue)
            begin
                if (idx_last)
                begin
                    walk_done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + VW'(1);
                end
            end

            // slot walk: only busy slots enter the pipeline
            s1_valid_reg <= issue && busy_reg[idx_reg];
            s1_idx_reg   <= idx_reg;
            s2_valid_reg <= s1_valid_reg && play;

            // finished voice frees its slot in the same tick
            if (s1_valid_reg && retire)
            begin
                busy_reg[s1_idx_reg] <= 1'b0;
                count_reg            <= count_reg - CW'(1);
            end

            if (done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            mix_reg        <= '0;
            q_addr_reg     <= item.address;
            q_count_reg    <= item.sample_count;
            res_status_reg <= mvsm_pkg::STATUS_OK;
            res_slot_reg   <= '0;
        end
        else
        begin
            if (q_take)
            begin
                res_slot_reg <= idx_reg;
            end
            else if ((state_reg == mvsm_pkg::ST_QUEUE) && idx_last)
            begin
                res_status_reg <= mvsm_pkg::STATUS_FULL;
            end

            // stage 2: running clipped sum in slot order
            if (s2_valid_reg)
            begin
                mix_reg <= mvsm_pkg::clip_add(mix_reg, sample_rd_data);
            end
        end

        if (done_load)
        begin
            out_mixed_reg  <= mix_reg;
            out_status_reg <= res_status_reg;
            out_slot_reg   <= slot_ext[4:0];
            out_active_reg <= count_ext[4:0];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.mixed_sample  = out_mixed_reg;
    assign result.status        = out_status_reg;
    assign result.slot          = out_slot_reg;
    assign result.active_voices = out_active_reg;

endmodule

// ===== src/mvsm_sample_mem.sv =====
// pcm sample memory: one write port, one read port, registered read data
// depends on nothing but its parameters
module mvsm_sample_mem #(
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0] wr_addr,
    input  logic signed [15:0]              wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0] rd_addr,
    output logic signed [15:0]              rd_data
);

    logic signed [15:0] mem_array [SAMPLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

// ===== src/mvsm_voice_mem.sv =====
// voice state memory: start, length and position of each slot
// depends on mvsm_pkg for the entry type
module mvsm_voice_mem #(
    parameter int VOICES = 30,
    parameter int VW     = 5
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [VW-1:0]          wr_idx,
    input  mvsm_pkg::voice_entry_t wr_data,
    input  logic                   rd_en,
    input  logic [VW-1:0]          rd_idx,
    output mvsm_pkg::voice_entry_t rd_data
);

    mvsm_pkg::voice_entry_t mem_array [VOICES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_array[rd_idx];
        end
    end

endmodule
